[rtl/core/atf_pkg.sv]
// ----------------------------------------------------------------------------
// atf_pkg: shared types and constants for the accelerometer tilt filter
// Fixed-point widths, register indexes, CORDIC arctangent table and the
// record that moves from cell to cell along the CORDIC row.
// ----------------------------------------------------------------------------
package atf_pkg;

  // Sample and angle widths.
  localparam int SAMPLE_W        = 16;
  localparam int ANGLE_W         = 16;
  localparam int LIMIT_W         = 15;
  localparam int ANGLE_FRAC_BITS = 8;

  // Square root datapath: radicand is the sum of squares scaled by 2^16.
  localparam int SQ_W       = 48;
  localparam int ROOT_W     = 24;
  localparam int ROOT_STEPS = 24;
  localparam int ROOT_CNT_W = 5;

  // CORDIC datapath widths and step limits.
  localparam int XY_W           = 27;
  localparam int Z_W            = 25;
  localparam int CORDIC_MAX     = 24;
  localparam int CORDIC_DEF     = 16;
  localparam int Z_SHIFT        = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [Z_W-1:0] Z_ROUND = Z_W'(1) <<< (15 - ANGLE_FRAC_BITS);

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROLL_OFFSET  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 8'd3;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET      = 15'd2560;
  localparam logic [LIMIT_W-1:0]   DBAND_RESET      = 15'd768;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE, S_SQR, S_START, S_ROOT, S_INJ0, S_INJ1, S_WAIT, S_COND, S_CWAIT, S_HOLD
  } st_t;

  // One item in flight along the CORDIC row.
  typedef struct packed {
    logic                  vld;
    logic                  tag;   // 0 pitch, 1 roll
    logic                  zero;  // zero vector, angle forced to 0
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cord_t;

  // atan(2^-i) in degrees with 16 fraction bits.
  function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      0:  a = 25'sd2949120;
      1:  a = 25'sd1740967;
      2:  a = 25'sd919879;
      3:  a = 25'sd466945;
      4:  a = 25'sd234379;
      5:  a = 25'sd117304;
      6:  a = 25'sd58666;
      7:  a = 25'sd29335;
      8:  a = 25'sd14668;
      9:  a = 25'sd7334;
      10: a = 25'sd3667;
      11: a = 25'sd1833;
      12: a = 25'sd917;
      13: a = 25'sd458;
      14: a = 25'sd229;
      15: a = 25'sd115;
      16: a = 25'sd57;
      17: a = 25'sd29;
      18: a = 25'sd14;
      19: a = 25'sd7;
      20: a = 25'sd4;
      21: a = 25'sd2;
      22: a = 25'sd1;
      default: a = 25'sd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/core/atf_isqrt.sv]
// ----------------------------------------------------------------------------
// atf_isqrt: iterative integer square root
// Floor square root of a 48-bit radicand, one result bit per cycle.
// ----------------------------------------------------------------------------
module atf_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [atf_pkg::SQ_W-1:0]    radicand,
  output logic                        done,
  output logic [atf_pkg::ROOT_W-1:0]  root
);
  import atf_pkg::*;

  logic [SQ_W-1:0]       v_r, v_nxt;
  logic [SQ_W-1:0]       res_r, res_nxt;
  logic [SQ_W-1:0]       bit_r, bit_nxt;
  logic [SQ_W-1:0]       trial;
  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // One restoring step: subtract the trial value when it fits.
  always_comb begin
    trial    = res_r + bit_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt    = radicand;
      res_nxt  = '0;
      bit_nxt  = SQ_W'(1) << (SQ_W - 2);
      cnt_nxt  = ROOT_CNT_W'(ROOT_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ROOT_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

[rtl/core/atf_cell.sv]
// ----------------------------------------------------------------------------
// atf_cell: one vectoring CORDIC rotation
// Rotates toward the x axis by atan(2^-IDX) and hands the item on.
// ----------------------------------------------------------------------------
module atf_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  atf_pkg::cord_t din,
  output atf_pkg::cord_t dout
);
  import atf_pkg::*;

  localparam logic signed [Z_W-1:0] ATAN = atan_deg(IDX);

  cord_t                  q_r, q_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  // Rotate positive on a zero residual; only y above zero rotates negative.
  always_comb begin
    dx    = din.y >>> IDX;
    dy    = din.x >>> IDX;
    q_nxt = din;
    if (din.y > 0) begin
      q_nxt.x = din.x + dx;
      q_nxt.y = din.y - dy;
      q_nxt.z = din.z + ATAN;
    end else begin
      q_nxt.x = din.x - dx;
      q_nxt.y = din.y + dy;
      q_nxt.z = din.z - ATAN;
    end
  end

  // Valid bit is control and is reset; the rest is payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.vld <= 1'b0;
    end else begin
      q_r.vld <= q_nxt.vld;
    end
    q_r.tag  <= q_nxt.tag;
    q_r.zero <= q_nxt.zero;
    q_r.x    <= q_nxt.x;
    q_r.y    <= q_nxt.y;
    q_r.z    <= q_nxt.z;
  end

  assign dout = q_r;

endmodule

[rtl/core/atf_cond.sv]
// ----------------------------------------------------------------------------
// atf_cond: angle conditioning
// Offset removal, clamp, dead band and averaging with the previous value.
// ----------------------------------------------------------------------------
module atf_cond (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [atf_pkg::ANGLE_W-1:0] raw,
  input  logic signed [atf_pkg::ANGLE_W-1:0] offset,
  input  logic [atf_pkg::LIMIT_W-1:0]        limit,
  input  logic [atf_pkg::LIMIT_W-1:0]        dband,
  output logic                               done,
  output logic signed [atf_pkg::ANGLE_W-1:0] angle
);
  import atf_pkg::*;

  logic signed [ANGLE_W:0]   diff;
  logic signed [ANGLE_W:0]   lim;
  logic signed [ANGLE_W-1:0] v_nxt, v_r;
  logic                      vld_r;
  logic [ANGLE_W-1:0]        mag;
  logic signed [ANGLE_W-1:0] vd;
  logic signed [ANGLE_W:0]   sum;
  logic signed [ANGLE_W-1:0] last_r, last_nxt;
  logic                      done_r;

  // First stage: subtract the offset at full width and clamp.
  always_comb begin
    diff = (ANGLE_W+1)'(raw) - (ANGLE_W+1)'(offset);
    lim  = signed'({2'b00, limit});
    if (diff > lim) begin
      v_nxt = ANGLE_W'(lim);
    end else if (diff < -lim) begin
      v_nxt = ANGLE_W'(-lim);
    end else begin
      v_nxt = ANGLE_W'(diff);
    end
  end

  // Second stage: dead band, then floor average with the last value.
  always_comb begin
    mag      = v_r[ANGLE_W-1] ? ANGLE_W'(-v_r) : ANGLE_W'(v_r);
    vd       = (mag < ANGLE_W'(dband)) ? '0 : v_r;
    sum      = (ANGLE_W+1)'(last_r) + (ANGLE_W+1)'(vd);
    last_nxt = sum[ANGLE_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      done_r <= 1'b0;
      last_r <= '0;
    end else begin
      vld_r  <= start;
      done_r <= vld_r;
      if (vld_r) begin
        last_r <= last_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  assign done  = done_r;
  assign angle = last_r;

endmodule

[rtl/core/accel_tilt_angle_filter.sv]
// Sequence: an accepted item passes the squares register, the square root loop,
// the CORDIC row and the conditioning units on its way to the output register.
// No new item is taken until the last one reaches the output register. The
// square root loop and the CORDIC row (roll enters the row in the cycle after
// pitch) are the longest steps. A new item is taken while a result waits.
// Reset (rst_n, synchronous, active low) clears the sequencer, the smoothed
// angles and restores the register defaults.
// ----------------------------------------------------------------------------
// accel_tilt_angle_filter: pitch and roll from a three-axis sample
// Square root of the sums of squares, a row of CORDIC cells for atan2, then
// offset, clamp, dead band and averaging of each angle.
// ----------------------------------------------------------------------------
module accel_tilt_angle_filter #(
  parameter int CORDIC_STEPS = atf_pkg::CORDIC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Sample input item.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
  // Angle result item.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pitch_angle [15:0], roll_angle [31:16]
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [atf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import atf_pkg::*;

  localparam int NCELL = (CORDIC_STEPS > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STEPS;

  st_t state_r, state_nxt;

  logic signed [SAMPLE_W-1:0] ax_r, ay_r, az_r;
  logic [2*SAMPLE_W-2:0]      sqx_r, sqy_r, sqz_r;
  logic signed [2*SAMPLE_W-1:0] px, py, pz;
  logic [SQ_W-1:0]            rad_p, rad_r;
  logic                       p_done, r_done;
  logic [ROOT_W-1:0]          root_p, root_r;
  logic signed [ANGLE_W-1:0]  praw_r, rraw_r;
  logic signed [ANGLE_W-1:0]  exit_ang;
  logic signed [Z_W-1:0]      zr;
  logic                       sq_start, cond_start;
  logic                       p_cdone, r_cdone;
  logic signed [ANGLE_W-1:0]  p_ang, r_ang;
  logic signed [ANGLE_W-1:0]  pofs_r, rofs_r;
  logic [LIMIT_W-1:0]         limit_r, dband_r;
  logic [31:0]                out_data_r;
  logic                       out_vld_r;
  logic                       out_free;
  cord_t                      row_in;
  cord_t                      chain [NCELL+1];

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_vld_r || out_tready;
  assign sq_start   = (state_r == S_START);
  assign cond_start = (state_r == S_COND);

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pofs_r  <= '0;
      rofs_r  <= '0;
      limit_r <= LIMIT_RESET;
      dband_r <= DBAND_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PITCH_OFFSET: pofs_r  <= cfg_data;
        REG_ROLL_OFFSET:  rofs_r  <= cfg_data;
        REG_ANGLE_LIMIT:  limit_r <= cfg_data[LIMIT_W-1:0];
        REG_DEAD_BAND:    dband_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample capture and squares.
  always_comb begin
    px    = ax_r * ax_r;
    py    = ay_r * ay_r;
    pz    = az_r * az_r;
    rad_p = {(SQ_W-16)'({1'b0, sqy_r} + {1'b0, sqz_r}), 16'b0};
    rad_r = {(SQ_W-16)'({1'b0, sqx_r} + {1'b0, sqz_r}), 16'b0};
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      ax_r <= in_tdata[15:0];
      ay_r <= in_tdata[31:16];
      az_r <= in_tdata[47:32];
    end
    if (state_r == S_SQR) begin
      sqx_r <= px[2*SAMPLE_W-2:0];
      sqy_r <= py[2*SAMPLE_W-2:0];
      sqz_r <= pz[2*SAMPLE_W-2:0];
    end
  end

  // Square roots for both angles run side by side.
  atf_isqrt u_root_p (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(rad_p),
    .done(p_done), .root(root_p)
  );

  atf_isqrt u_root_r (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .radicand(rad_r),
    .done(r_done), .root(root_r)
  );

  // Row entry: pitch first, roll in the next cycle.
  always_comb begin
    row_in     = '0;
    row_in.vld = (state_r == S_INJ0) || (state_r == S_INJ1);
    if (state_r == S_INJ1) begin
      row_in.tag  = 1'b1;
      row_in.x    = signed'({(XY_W-ROOT_W)'(0), root_r});
      row_in.y    = signed'({{(XY_W-SAMPLE_W-8){ay_r[SAMPLE_W-1]}}, ay_r, 8'b0});
      row_in.zero = (root_r == '0) && (ay_r == '0);
    end else begin
      row_in.tag  = 1'b0;
      row_in.x    = signed'({(XY_W-ROOT_W)'(0), root_p});
      row_in.y    = signed'({{(XY_W-SAMPLE_W-8){ax_r[SAMPLE_W-1]}}, ax_r, 8'b0});
      row_in.zero = (root_p == '0) && (ax_r == '0);
    end
  end

  assign chain[0] = row_in;

  // Row of CORDIC cells.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    atf_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .din(chain[i]), .dout(chain[i+1])
    );
  end

  // Round the accumulated angle to the output fraction bits.
  always_comb begin
    zr       = chain[NCELL].z + Z_ROUND;
    exit_ang = chain[NCELL].zero ? '0 : ANGLE_W'(zr >>> Z_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (chain[NCELL].vld && !chain[NCELL].tag) begin
      praw_r <= exit_ang;
    end
    if (chain[NCELL].vld && chain[NCELL].tag) begin
      rraw_r <= exit_ang;
    end
  end

  // Conditioning of each angle; each keeps its own previous value.
  atf_cond u_cond_p (
    .clk(clk), .rst_n(rst_n), .start(cond_start), .raw(praw_r), .offset(pofs_r),
    .limit(limit_r), .dband(dband_r), .done(p_cdone), .angle(p_ang)
  );

  atf_cond u_cond_r (
    .clk(clk), .rst_n(rst_n), .start(cond_start), .raw(rraw_r), .offset(rofs_r),
    .limit(limit_r), .dband(dband_r), .done(r_cdone), .angle(r_ang)
  );

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_SQR;
      S_SQR:   state_nxt = S_START;
      S_START: state_nxt = S_ROOT;
      S_ROOT:  if (p_done) state_nxt = S_INJ0;
      S_INJ0:  state_nxt = S_INJ1;
      S_INJ1:  state_nxt = S_WAIT;
      S_WAIT:  if (chain[NCELL].vld && chain[NCELL].tag) state_nxt = S_COND;
      S_COND:  state_nxt = S_CWAIT;
      S_CWAIT: if (p_cdone) state_nxt = S_HOLD;
      S_HOLD:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == S_HOLD && out_free) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_HOLD && out_free) begin
      out_data_r <= {r_ang, p_ang};
    end
  end

`ifndef SYNTHESIS
  a_root_pair: assert property (@(posedge clk) disable iff (!rst_n)
    p_done == r_done) else $error("square root units out of step");
  a_cond_pair: assert property (@(posedge clk) disable iff (!rst_n)
    p_cdone == r_cdone) else $error("conditioning units out of step");
  a_exit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    chain[NCELL].vld |-> state_r == S_WAIT) else $error("CORDIC item left outside wait");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == S_SQR) else $error("accepted item lost");
`endif

endmodule
